FILE: hw/rtl/bdh_pkg.sv
// Shared constants, register codes and types of the box difference hash block.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package bdh_pkg;

  // Default sizing of the core
  localparam int DEF_MAX_WIDTH      = 4096;
  localparam int DEF_MAX_HEIGHT     = 4096;
  localparam int DEF_SAMPLE_COLUMNS = 9;
  localparam int DEF_SAMPLE_ROWS    = 8;

  // Pixel and hash words
  localparam int COLOR_W         = 8;
  localparam int LUMA_W          = 18;
  localparam int HASH_W          = 64;
  localparam int HASH_ROW_STRIDE = 8;

  // Integer luma weights, scaled by 1000
  localparam int LUMA_R_WEIGHT = 299;
  localparam int LUMA_G_WEIGHT = 587;
  localparam int LUMA_B_WEIGHT = 114;

  // Configuration port
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_SIZE_W   = 13;
  localparam int CFG_ORIGIN_W = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_BOX_LEFT     = 3'd2,
    REG_BOX_TOP      = 3'd3,
    REG_BOX_SPAN_X   = 3'd4,
    REG_BOX_SPAN_Y   = 3'd5
  } cfg_reg_e;

  localparam logic [CFG_SIZE_W-1:0]   RST_IMAGE_WIDTH  = 13'd64;
  localparam logic [CFG_SIZE_W-1:0]   RST_IMAGE_HEIGHT = 13'd64;
  localparam logic [CFG_ORIGIN_W-1:0] RST_BOX_LEFT     = 12'd0;
  localparam logic [CFG_ORIGIN_W-1:0] RST_BOX_TOP      = 12'd0;
  localparam logic [CFG_SIZE_W-1:0]   RST_BOX_SPAN_X   = 13'd64;
  localparam logic [CFG_SIZE_W-1:0]   RST_BOX_SPAN_Y   = 13'd64;

  typedef struct packed {
    logic [CFG_SIZE_W-1:0]   image_width;
    logic [CFG_SIZE_W-1:0]   image_height;
    logic [CFG_ORIGIN_W-1:0] box_left;
    logic [CFG_ORIGIN_W-1:0] box_top;
    logic [CFG_SIZE_W-1:0]   box_span_x;
    logic [CFG_SIZE_W-1:0]   box_span_y;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bdh_pixel_if.sv
// Pixel stream channel: valid/ready handshake with an RGB word.
// Uses bdh_pkg for the color width.
`default_nettype none

interface bdh_pixel_if import bdh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bdh_hash_if.sv
// Hash result channel: valid/ready handshake with a 64-bit hash word.
// Uses bdh_pkg for the hash width.
`default_nettype none

interface bdh_hash_if import bdh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash;

  modport source (output valid, output hash, input ready);
  modport sink   (input valid, input hash, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bdh_axis.sv
// One axis of the sample grid: clamps size, box start and span, then sweeps
// the sample positions start + min(span-1, k*span/COUNT) one per cycle.
// Depends on bdh_pkg.
`default_nettype none

module bdh_axis import bdh_pkg::*; #(
  parameter int MAX_SIZE = DEF_MAX_WIDTH,
  parameter int COUNT    = DEF_SAMPLE_COLUMNS,
  localparam int SW = (CFG_SIZE_W > $clog2(MAX_SIZE + 1)) ? CFG_SIZE_W
                                                          : $clog2(MAX_SIZE + 1),
  localparam int PW = $clog2(MAX_SIZE)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [CFG_SIZE_W-1:0]   size_i,
  input  wire logic [CFG_ORIGIN_W-1:0] origin_i,
  input  wire logic [CFG_SIZE_W-1:0]   span_i,
  output logic                         busy_o,
  output logic [SW-1:0]                size_o,
  output logic [PW-1:0]                pos_o [COUNT]
);

  localparam int CW    = $clog2(COUNT);
  localparam int VW    = SW + CW;          // k*span for k < COUNT
  localparam int SH    = VW + CW;          // reciprocal shift
  localparam int RW    = VW + 1;
  localparam int PRW   = VW + RW;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << SH) + 64'(COUNT) - 64'd1) / 64'(COUNT));
  localparam int STW   = $clog2(COUNT + 5);
  localparam int FIRST_ACC = 3;
  localparam int FIRST_WR  = 4;
  localparam logic [STW-1:0] LAST_STEP = STW'(COUNT + 3);

  logic           busy_q;
  logic [STW-1:0] step_q;
  logic [SW-1:0]  size_q, size_d;
  logic [SW-1:0]  start_q, start_d;
  logic [SW-1:0]  span_q, span_d;
  logic [VW-1:0]  acc_q, acc_d;
  logic [PRW-1:0] prod_q;
  logic [SW-1:0]  quot, lim, pos_w;
  logic [SW-1:0]  size_in, origin_in, span_in, room;
  logic [PW-1:0]  pos_q [COUNT];

  // Sequencer: restart the sweep on every configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      if (step_q == LAST_STEP) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_comb begin
    size_in   = SW'(size_i);
    origin_in = SW'(origin_i);
    span_in   = SW'(span_i);

    if (size_in == '0) begin
      size_d = SW'(1);
    end else if (size_in > SW'(MAX_SIZE)) begin
      size_d = SW'(MAX_SIZE);
    end else begin
      size_d = size_in;
    end

    start_d = (origin_in < size_q - 1'b1) ? origin_in : size_q - 1'b1;

    room = size_q - start_q;
    if (span_in == '0) begin
      span_d = SW'(1);
    end else if (span_in > room) begin
      span_d = room;
    end else begin
      span_d = span_in;
    end

    acc_d = (step_q < STW'(FIRST_ACC)) ? '0 : acc_q + VW'(span_q);

    quot  = prod_q[SH +: SW];
    lim   = span_q - 1'b1;
    pos_w = start_q + ((quot < lim) ? quot : lim);
  end

  // Clamp chain settles one stage per cycle while the sweep waits
  always_ff @(posedge clk_i) begin
    size_q  <= size_d;
    start_q <= start_d;
    span_q  <= span_d;
    acc_q   <= acc_d;
    prod_q  <= PRW'(acc_q) * PRW'(RECIP);
  end

  for (genvar k = 0; k < COUNT; k++) begin : g_pos
    always_ff @(posedge clk_i) begin
      if (busy_q && step_q == STW'(k + FIRST_WR)) begin
        pos_q[k] <= PW'(pos_w);
      end
    end
    assign pos_o[k] = pos_q[k];
  end

  assign busy_o = busy_q;
  assign size_o = size_q;

endmodule

`default_nettype wire

FILE: hw/rtl/box_difference_hash_core.sv
// Top level of the box difference hash core: configuration registers, raster
// counters, sample row store and hash accumulator.
// Depends on bdh_pkg, bdh_pixel_if, bdh_hash_if and bdh_axis.
//
//   channel   dir  handshake           word
//   pixel_i   in   valid/ready         red, green, blue (8 bits each)
//   hash_o    out  valid/ready         hash (64 bits), once per frame
//   cfg       in   cfg_we_i, no wait   cfg_index_i, cfg_data_i
//
// One pixel per cycle unless the pipe is stalled: a pixel is registered with its
// luma and grid hits, and the process stage then updates the sample row and the
// hash; the hash comes out of its own register once the frame's last pixel is processed.
// After reset and after each configuration write, pixel_i.ready stays low
// while the sample positions are recomputed, one per cycle per axis.
// A waiting hash stalls the pipe only when the next frame's last pixel arrives.
`default_nettype none

module box_difference_hash_core import bdh_pkg::*; #(
  parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
  parameter int SAMPLE_COLUMNS = DEF_SAMPLE_COLUMNS,
  parameter int SAMPLE_ROWS    = DEF_SAMPLE_ROWS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  bdh_pixel_if.sink                   pixel_i,
  bdh_hash_if.source                  hash_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int SWX = (CFG_SIZE_W > $clog2(MAX_WIDTH + 1)) ? CFG_SIZE_W
                                                            : $clog2(MAX_WIDTH + 1);
  localparam int SWY = (CFG_SIZE_W > $clog2(MAX_HEIGHT + 1)) ? CFG_SIZE_W
                                                             : $clog2(MAX_HEIGHT + 1);

  cfg_t cfg_q;

  logic            busy_x, busy_y;
  logic [SWX-1:0]  width;
  logic [SWY-1:0]  height;
  logic [XW-1:0]   col_pos [SAMPLE_COLUMNS];
  logic [YW-1:0]   row_pos [SAMPLE_ROWS];

  logic [XW-1:0]   col_q, col_d;
  logic [YW-1:0]   row_q, row_d;
  logic            eol, eof;

  logic                      s1_valid_q, s1_valid_d;
  logic [LUMA_W-1:0]         s1_luma_q, luma;
  logic [SAMPLE_COLUMNS-1:0] s1_colhit_q, colhit;
  logic [SAMPLE_ROWS-1:0]    s1_rowhit_q, rowhit;
  logic                      s1_eof_q;

  logic [LUMA_W-1:0] samp_q   [SAMPLE_COLUMNS];
  logic [LUMA_W-1:0] samp_new [SAMPLE_COLUMNS];
  logic [HASH_W-1:0] bits, acc_q, acc_d, hash_q;
  logic              out_valid_q, out_valid_d;

  logic in_ready, accept, fire;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= RST_IMAGE_WIDTH;
      cfg_q.image_height <= RST_IMAGE_HEIGHT;
      cfg_q.box_left     <= RST_BOX_LEFT;
      cfg_q.box_top      <= RST_BOX_TOP;
      cfg_q.box_span_x   <= RST_BOX_SPAN_X;
      cfg_q.box_span_y   <= RST_BOX_SPAN_Y;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data_i[CFG_SIZE_W-1:0];
        REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i[CFG_SIZE_W-1:0];
        REG_BOX_LEFT:     cfg_q.box_left     <= cfg_data_i[CFG_ORIGIN_W-1:0];
        REG_BOX_TOP:      cfg_q.box_top      <= cfg_data_i[CFG_ORIGIN_W-1:0];
        REG_BOX_SPAN_X:   cfg_q.box_span_x   <= cfg_data_i[CFG_SIZE_W-1:0];
        REG_BOX_SPAN_Y:   cfg_q.box_span_y   <= cfg_data_i[CFG_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  bdh_axis #(
    .MAX_SIZE (MAX_WIDTH),
    .COUNT    (SAMPLE_COLUMNS)
  ) u_axis_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cfg_we_i),
    .size_i   (cfg_q.image_width),
    .origin_i (cfg_q.box_left),
    .span_i   (cfg_q.box_span_x),
    .busy_o   (busy_x),
    .size_o   (width),
    .pos_o    (col_pos)
  );

  bdh_axis #(
    .MAX_SIZE (MAX_HEIGHT),
    .COUNT    (SAMPLE_ROWS)
  ) u_axis_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cfg_we_i),
    .size_i   (cfg_q.image_height),
    .origin_i (cfg_q.box_top),
    .span_i   (cfg_q.box_span_y),
    .busy_o   (busy_y),
    .size_o   (height),
    .pos_o    (row_pos)
  );

  // Handshake: process stage drains unless a frame end meets a full output
  assign fire     = s1_valid_q && (!s1_eof_q || !out_valid_q || hash_o.ready);
  assign in_ready = !busy_x && !busy_y && (!s1_valid_q || fire);
  assign accept   = pixel_i.valid && in_ready;
  assign pixel_i.ready = in_ready;

  // Accept stage: luma, grid hits and raster position
  always_comb begin
    luma = LUMA_W'(LUMA_R_WEIGHT) * LUMA_W'(pixel_i.red)
         + LUMA_W'(LUMA_G_WEIGHT) * LUMA_W'(pixel_i.green)
         + LUMA_W'(LUMA_B_WEIGHT) * LUMA_W'(pixel_i.blue);

    for (int x = 0; x < SAMPLE_COLUMNS; x++) begin
      colhit[x] = (col_pos[x] == col_q);
    end
    for (int y = 0; y < SAMPLE_ROWS; y++) begin
      rowhit[y] = (row_pos[y] == row_q);
    end

    eol = (SWX'(col_q) + 1'b1) >= width;
    eof = eol && ((SWY'(row_q) + 1'b1) >= height);

    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (eol) begin
        col_d = '0;
        row_d = eof ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end

    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_luma_q   <= luma;
      s1_colhit_q <= colhit;
      s1_rowhit_q <= rowhit;
      s1_eof_q    <= eof;
    end
  end

  // Process stage: store the sample, compare neighbors on the last column
  always_comb begin
    for (int x = 0; x < SAMPLE_COLUMNS; x++) begin
      samp_new[x] = s1_colhit_q[x] ? s1_luma_q : samp_q[x];
    end

    bits = '0;
    for (int y = 0; y < SAMPLE_ROWS; y++) begin
      for (int x = 0; x < SAMPLE_COLUMNS - 1; x++) begin
        bits[y * HASH_ROW_STRIDE + x] = s1_rowhit_q[y] && s1_colhit_q[SAMPLE_COLUMNS-1]
                                        && (samp_new[x] > samp_new[x+1]);
      end
    end

    acc_d = acc_q;
    if (fire) begin
      acc_d = s1_eof_q ? '0 : (acc_q | bits);
    end

    out_valid_d = out_valid_q;
    if (fire && s1_eof_q) begin
      out_valid_d = 1'b1;
    end else if (hash_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int x = 0; x < SAMPLE_COLUMNS; x++) begin
        samp_q[x] <= samp_new[x];
      end
    end
    if (fire && s1_eof_q) begin
      hash_q <= acc_q | bits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign hash_o.valid = out_valid_q;
  assign hash_o.hash  = hash_q;

endmodule

`default_nettype wire

FILE: test/box_difference_hash_core_tb.sv
// Testbench for box_difference_hash_core: streams RGB frames under a series of
// box and frame settings and checks every hash word against a built-in predictor or a typed probe hash.
// Depends on bdh_pkg, bdh_pixel_if and bdh_hash_if; needs nothing but the RTL.
`default_nettype none

module box_difference_hash_core_tb;
  import bdh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_SIDE      = 4096;
  localparam int unsigned GRID_COLS     = 9;
  localparam int unsigned GRID_ROWS     = 8;
  localparam int unsigned R_WEIGHT      = 299;
  localparam int unsigned G_WEIGHT      = 587;
  localparam int unsigned B_WEIGHT      = 114;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned RANDOM_PIXELS = 1300;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               typed;
    logic [HASH_W-1:0]  hash;
  } probe_t;

  // 9x1 frame, box spans the row: every hash row is filled from row 0.
  // First frame: strictly darker to the right, so every bit is set.
  // Second frame: pure channels, a tie between two greens.
  localparam int PROBE_COUNT = 18;
  localparam probe_t PROBES [PROBE_COUNT] = '{
    '{8'd255, 8'd255, 8'd255, 1'b0, 64'd0},
    '{8'd223, 8'd223, 8'd223, 1'b0, 64'd0},
    '{8'd191, 8'd191, 8'd191, 1'b0, 64'd0},
    '{8'd159, 8'd159, 8'd159, 1'b0, 64'd0},
    '{8'd127, 8'd127, 8'd127, 1'b0, 64'd0},
    '{8'd95,  8'd95,  8'd95,  1'b0, 64'd0},
    '{8'd63,  8'd63,  8'd63,  1'b0, 64'd0},
    '{8'd31,  8'd31,  8'd31,  1'b0, 64'd0},
    '{8'd0,   8'd0,   8'd0,   1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    '{8'd0,   8'd0,   8'd255, 1'b0, 64'd0},
    '{8'd255, 8'd0,   8'd0,   1'b0, 64'd0},
    '{8'd0,   8'd255, 8'd0,   1'b0, 64'd0},
    '{8'd0,   8'd255, 8'd0,   1'b0, 64'd0},
    '{8'd255, 8'd255, 8'd255, 1'b0, 64'd0},
    '{8'd0,   8'd0,   8'd0,   1'b0, 64'd0},
    '{8'd255, 8'd255, 8'd0,   1'b0, 64'd0},
    '{8'd0,   8'd255, 8'd255, 1'b0, 64'd0},
    '{8'd255, 8'd0,   8'd255, 1'b0, 64'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  bdh_pixel_if pix ();
  bdh_hash_if  hsh ();

  box_difference_hash_core #(
    .MAX_WIDTH      (MAX_SIDE),
    .MAX_HEIGHT     (MAX_SIDE),
    .SAMPLE_COLUMNS (GRID_COLS),
    .SAMPLE_ROWS    (GRID_ROWS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pixel_i     (pix),
    .hash_o      (hsh),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state: register copy, raster position, sample row, hash bits
  cfg_t                   live_cfg = '{13'd64, 13'd64, 12'd0, 12'd0, 13'd64, 13'd64};
  logic [11:0]            col_pos = '0;
  logic [11:0]            row_pos = '0;
  logic [LUMA_W-1:0]      row_luma [GRID_COLS];
  logic [HASH_W-1:0]      hash_bits = '0;
  logic [HASH_W-1:0]      hash_due [$];

  int unsigned pixels_sent;
  int unsigned hashes_checked;
  int unsigned settings_used;
  int unsigned faults;
  int unsigned quiet_cycles;
  int unsigned hold_ticket;
  bit          calm;

  function automatic int unsigned bound(input int unsigned v, lo, hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Nearest-neighbour grid point k of count along one axis of the clamped box
  function automatic int unsigned grid_point(input int unsigned origin, span, k, count);
    int unsigned off;
    off = (k * span) / count;
    if (off > span - 1) off = span - 1;
    return origin + off;
  endfunction

  task automatic absorb_pixel(input logic [COLOR_W-1:0] r, g, b,
                              output bit ended, output logic [HASH_W-1:0] frame_hash);
    int unsigned w, h, bx, by, bw, bh, luma, col, row;
    w = bound(live_cfg.image_width, 1, MAX_SIDE);
    h = bound(live_cfg.image_height, 1, MAX_SIDE);
    bx = (live_cfg.box_left < w - 1) ? live_cfg.box_left : w - 1;
    by = (live_cfg.box_top < h - 1) ? live_cfg.box_top : h - 1;
    bw = bound(live_cfg.box_span_x, 1, w - bx);
    bh = bound(live_cfg.box_span_y, 1, h - by);
    luma = R_WEIGHT * r + G_WEIGHT * g + B_WEIGHT * b;
    col = col_pos;
    row = row_pos;
    ended = 1'b0;
    frame_hash = '0;
    for (int x = 0; x < GRID_COLS; x++)
      if (grid_point(bx, bw, x, GRID_COLS) == col) row_luma[x] = luma[LUMA_W-1:0];
    // last sample column closes every hash row that maps onto this image row
    if (grid_point(bx, bw, GRID_COLS - 1, GRID_COLS) == col) begin
      for (int y = 0; y < GRID_ROWS; y++) begin
        if (grid_point(by, bh, y, GRID_ROWS) == row) begin
          for (int x = 0; x + 1 < GRID_COLS; x++)
            if (row_luma[x] > row_luma[x+1]) hash_bits[y*HASH_ROW_STRIDE + x] = 1'b1;
        end
      end
    end
    if (col + 1 >= w) begin
      col_pos = '0;
      if (row + 1 >= h) begin
        row_pos = '0;
        frame_hash = hash_bits;
        hash_bits = '0;
        ended = 1'b1;
      end else begin
        row_pos = 12'(row + 1);
      end
    end else begin
      col_pos = 12'(col + 1);
    end
  endtask

  function automatic logic [COLOR_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return COLOR_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [COLOR_W-1:0] r, g, b,
                            input logic typed, input logic [HASH_W-1:0] typed_hash);
    bit                ended;
    logic [HASH_W-1:0] predicted;
    if (!calm && $urandom_range(0, 99) < 9) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    pixels_sent++;
    absorb_pixel(r, g, b, ended, predicted);
    if (ended) hash_due.insert(hash_due.size(), typed ? typed_hash : predicted);
  endtask

  // Drop valid, wait for every hash word, then let the pipe run dry
  task automatic drain();
    pix.valid <= 1'b0;
    while (hash_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic drive_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      REG_IMAGE_WIDTH:  live_cfg.image_width  = data;
      REG_IMAGE_HEIGHT: live_cfg.image_height = data;
      REG_BOX_LEFT:     live_cfg.box_left     = data[CFG_ORIGIN_W-1:0];
      REG_BOX_TOP:      live_cfg.box_top      = data[CFG_ORIGIN_W-1:0];
      REG_BOX_SPAN_X:   live_cfg.box_span_x   = data;
      REG_BOX_SPAN_Y:   live_cfg.box_span_y   = data;
      default: ;
    endcase
  endtask

  task automatic program_setting(input logic [CFG_DATA_W-1:0] w, h, l, t, sx, sy);
    drain();
    drive_reg(REG_IMAGE_WIDTH, w);
    drive_reg(REG_IMAGE_HEIGHT, h);
    drive_reg(REG_BOX_LEFT, l);
    drive_reg(REG_BOX_TOP, t);
    drive_reg(REG_BOX_SPAN_X, sx);
    drive_reg(REG_BOX_SPAN_Y, sy);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Mostly small frames; now and then a degenerate size or a box off the frame
  task automatic program_random_setting();
    logic [CFG_DATA_W-1:0] w, h, l, t, sx, sy;
    w  = ($urandom_range(0, 15) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 24));
    h  = ($urandom_range(0, 15) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 12));
    l  = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, w));
    t  = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, h));
    sx = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                     : CFG_DATA_W'($urandom_range(0, w + 3));
    sy = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                     : CFG_DATA_W'($urandom_range(0, h + 3));
    program_setting(w, h, l, t, sx, sy);
  endtask

  task automatic run_frames(input int unsigned frames);
    int unsigned count;
    count = frames * bound(live_cfg.image_width, 1, MAX_SIDE)
                   * bound(live_cfg.image_height, 1, MAX_SIDE);
    repeat (count) send_pixel(pick_level(), pick_level(), pick_level(), 1'b0, '0);
  endtask

  task automatic compare_hash(input logic [HASH_W-1:0] got);
    logic [HASH_W-1:0] want;
    if (hash_due.size() == 0) begin
      faults++;
      $display("%0t unexpected hash word: expected none, actual %h", $time, got);
    end else begin
      want = hash_due.pop_front();
      hashes_checked++;
      if (want !== got) begin
        faults++;
        $display("%0t hash mismatch: expected %h, actual %h", $time, want, got);
      end
    end
  endtask

  // Receiver: check words, idle at random, hold off when a stall is requested
  initial begin
    int unsigned hold_left;
    int unsigned hold_served;
    hold_left = 0;
    hold_served = 0;
    quiet_cycles = 0;
    hsh.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if ((pix.valid && pix.ready) || (hsh.valid && hsh.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (rst_ni && hsh.valid && hsh.ready) compare_hash(hsh.hash);
      if (hold_left != 0) begin
        hold_left--;
        hsh.ready <= 1'b0;
      end else if (hold_served != hold_ticket) begin
        hold_served = hold_ticket;
        hold_left = HOLD_CYCLES;
        hsh.ready <= 1'b0;
      end else begin
        hsh.ready <= calm || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t no handshake for %0d cycles, %0d hash words outstanding",
             $time, quiet_cycles, hash_due.size());
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned random_start;
    pix.valid   <= 1'b0;
    pix.red     <= '0;
    pix.green   <= '0;
    pix.blue    <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= REG_IMAGE_WIDTH;
    cfg_data_i  <= '0;
    calm = 1'b0;
    hold_ticket = 0;
    pixels_sent = 0;
    hashes_checked = 0;
    settings_used = 0;
    faults = 0;
    foreach (row_luma[i]) row_luma[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values except a single row: one 64x1 frame
    drive_reg(REG_IMAGE_HEIGHT, 13'd1);
    cfg_we_i <= 1'b0;
    run_frames(1);

    program_setting(13'd9, 13'd1, 13'd0, 13'd0, 13'd9, 13'd8);
    foreach (PROBES[i])
      send_pixel(PROBES[i].red, PROBES[i].green, PROBES[i].blue, PROBES[i].typed, PROBES[i].hash);

    // zero sizes clamp to a single pixel
    program_setting(13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0);
    run_frames(5);
    // box off the frame: collapses onto the last pixel
    program_setting(13'd20, 13'd10, 13'd8191, 13'd8191, 13'd8191, 13'd8191);
    run_frames(1);
    // spans run past the frame edge
    program_setting(13'd17, 13'd13, 13'd3, 13'd2, 13'd8191, 13'd8191);
    run_frames(1);

    random_start = pixels_sent;

    // sustained traffic, no gaps on either side
    calm = 1'b1;
    program_setting(13'd16, 13'd8, 13'd1, 13'd0, 13'd15, 13'd8);
    run_frames(3);
    calm = 1'b0;

    // tiny frames against a stalled receiver: fill up and back-pressure the input
    program_setting(13'd2, 13'd2, 13'd0, 13'd0, 13'd2, 13'd2);
    hold_ticket++;
    run_frames(30);

    while (pixels_sent < random_start + RANDOM_PIXELS) begin
      program_random_setting();
      run_frames($urandom_range(1, 4));
    end

    drain();
    $display("summary: %0d pixels over %0d register settings, %0d hash words checked",
             pixels_sent, settings_used, hashes_checked);
    $display("summary: directed gradients, clamped sizes and boxes, random boxes, %0d faults",
             faults);
    if (faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/bdh_pkg.sv
hw/rtl/bdh_pixel_if.sv
hw/rtl/bdh_hash_if.sv
hw/rtl/bdh_axis.sv
hw/rtl/box_difference_hash_core.sv
test/box_difference_hash_core_tb.sv
